FILE: hdl/rsi_pkg.sv
// Shared widths, register codes and pipeline stage types for the ray-sphere intersect block.
`timescale 1ns / 1ps

package rsi_pkg;

    localparam int ADDR_W      = 4;
    localparam int T_FRAC_BITS = 16;
    localparam int DISC_W      = 100;
    localparam int ROOT_W      = DISC_W / 2;
    localparam int SQ_STAGES   = ROOT_W;
    localparam int SREM_W      = ROOT_W + 3;
    localparam int Q_W         = 32;
    localparam int DV_STAGES   = Q_W;
    localparam int A_W         = 48;
    localparam int DREM_W      = A_W + Q_W;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_Z = 2'd2;
    localparam logic [1:0] REG_RADIUS   = 2'd3;

    localparam logic [31:0] T_MISS = 32'hFFFF_0000;
    localparam logic [31:0] T_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] T_MIN  = 32'h8000_0000;

    typedef struct packed {
        logic signed [24:0] lx;
        logic signed [24:0] ly;
        logic signed [24:0] lz;
        logic signed [23:0] dx;
        logic signed [23:0] dy;
        logic signed [23:0] dz;
    } s1_t;

    typedef struct packed {
        logic signed [47:0] dxx;
        logic signed [47:0] dyy;
        logic signed [47:0] dzz;
        logic signed [48:0] hx;
        logic signed [48:0] hy;
        logic signed [48:0] hz;
        logic signed [49:0] lxx;
        logic signed [49:0] lyy;
        logic signed [49:0] lzz;
        logic        [45:0] rr;
    } s2_t;

    typedef struct packed {
        logic        [A_W-1:0] a;
        logic signed [49:0]    h;
        logic signed [50:0]    c;
    } s3_t;

    typedef struct packed {
        logic        [A_W-1:0] a;
        logic signed [49:0]    h;
        logic                  miss;
        logic                  c_neg;
        logic        [47:0]    p_h11;
        logic        [48:0]    p_h10;
        logic        [49:0]    p_h00;
        logic        [48:0]    p_a1c1;
        logic        [48:0]    p_a1c0;
        logic        [48:0]    p_a0c1;
        logic        [48:0]    p_a0c0;
    } s4_t;

    typedef struct packed {
        logic        [A_W-1:0]    a;
        logic signed [49:0]       h;
        logic                     miss;
        logic                     c_neg;
        logic        [DISC_W-1:0] hh;
        logic        [DISC_W-1:0] ac;
    } s5_t;

    typedef struct packed {
        logic        [DISC_W-1:0] disc;
        logic        [SREM_W-1:0] rem;
        logic        [ROOT_W-1:0] root;
        logic signed [49:0]       h;
        logic        [A_W-1:0]    a;
        logic                     miss;
    } sq_t;

    typedef struct packed {
        logic [50:0]    nm;
        logic           neg;
        logic [A_W-1:0] a;
        logic           miss;
    } n1_t;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [Q_W-1:0]    q;
        logic [A_W-1:0]    a;
        logic              neg;
        logic              presat;
        logic              miss;
    } dv_t;

endpackage

FILE: hdl/ray_sphere_intersect.sv
// Ray-sphere intersection: fully pipelined, one ray in and one result out per cycle while m_axis does not stall.
`timescale 1ns / 1ps

//  Channel   Dir  Handshake            Payload
//  s_axis    in   tvalid/tready        tdata: origin x,y,z, dir x,y,z (24b each)
//  m_axis    out  tvalid/tready        tdata: t_value; tuser: hit, saturated
//  apb       in   psel/penable/pready  centre x,y,z, radius at 0x0,0x4,0x8,0xC
//
//  Pipeline: 6 front stages (subtract, products, sums, split products,
//  partial sums, discriminant), 50 square-root digit stages, 2 numerator stages,
//  32 divider stages and the output register. One ray per cycle sustained unless m_axis stalls.
//  Reset clears all valid bits and loads the default sphere.
//  A stall on m_axis freezes the whole pipe; s_axis_tready drops with it.

module ray_sphere_intersect #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rsi_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [143:0]               s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // t_value
    output logic [31:0]                m_axis_tdata,
    // hit, saturated
    output logic [1:0]                 m_axis_tuser
);
    import rsi_pkg::*;

    localparam logic [63:0] ONE_SHL = 64'd1 << COORD_FRAC_BITS;
    localparam logic [23:0] CZ_RST  = 24'(64'd0 - ONE_SHL);
    localparam logic [22:0] RAD_RST = 23'(ONE_SHL >> 1);

    logic signed [23:0] cx_reg, cy_reg, cz_reg;
    logic        [22:0] rad_reg;

    logic en;
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, s6_vld_reg;
    logic [SQ_STAGES-1:0] sq_vld_reg;
    logic n1_vld_reg, n2_vld_reg;
    logic [DV_STAGES-1:0] dv_vld_reg;
    logic out_vld_reg;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;
    sq_t s6_reg, s6_next;
    sq_t sq_reg  [SQ_STAGES];
    sq_t sq_prev [SQ_STAGES];
    sq_t sq_next [SQ_STAGES];
    n1_t n1_reg, n1_next;
    dv_t n2_reg, n2_next;
    dv_t dv_reg  [DV_STAGES];
    dv_t dv_prev [DV_STAGES];
    dv_t dv_next [DV_STAGES];

    logic [31:0] t_reg, t_next;
    logic        hit_reg, hit_next, sat_reg, sat_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= CZ_RST;
            rad_reg <= RAD_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[3:2])
                REG_CENTER_X: cx_reg  <= pwdata[23:0];
                REG_CENTER_Y: cy_reg  <= pwdata[23:0];
                REG_CENTER_Z: cz_reg  <= pwdata[23:0];
                REG_RADIUS:   rad_reg <= pwdata[22:0];
                default:      cx_reg  <= cx_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CENTER_X: prdata = {8'd0, cx_reg};
            REG_CENTER_Y: prdata = {8'd0, cy_reg};
            REG_CENTER_Z: prdata = {8'd0, cz_reg};
            REG_RADIUS:   prdata = {9'd0, rad_reg};
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // front stages
    always_comb
    begin
        logic signed [23:0] ox, oy, oz;
        logic [48:0] h_mag;
        logic [49:0] c_mag;
        ox = s_axis_tdata[23:0];
        oy = s_axis_tdata[47:24];
        oz = s_axis_tdata[71:48];
        s1_next.dx = s_axis_tdata[95:72];
        s1_next.dy = s_axis_tdata[119:96];
        s1_next.dz = s_axis_tdata[143:120];
        s1_next.lx = 25'(cx_reg) - 25'(ox);
        s1_next.ly = 25'(cy_reg) - 25'(oy);
        s1_next.lz = 25'(cz_reg) - 25'(oz);

        s2_next.dxx = s1_reg.dx * s1_reg.dx;
        s2_next.dyy = s1_reg.dy * s1_reg.dy;
        s2_next.dzz = s1_reg.dz * s1_reg.dz;
        s2_next.hx  = s1_reg.dx * s1_reg.lx;
        s2_next.hy  = s1_reg.dy * s1_reg.ly;
        s2_next.hz  = s1_reg.dz * s1_reg.lz;
        s2_next.lxx = s1_reg.lx * s1_reg.lx;
        s2_next.lyy = s1_reg.ly * s1_reg.ly;
        s2_next.lzz = s1_reg.lz * s1_reg.lz;
        s2_next.rr  = 46'(rad_reg) * 46'(rad_reg);

        s3_next.a = 48'(s2_reg.dxx) + 48'(s2_reg.dyy) + 48'(s2_reg.dzz);
        s3_next.h = 50'(s2_reg.hx) + 50'(s2_reg.hy) + 50'(s2_reg.hz);
        s3_next.c = 51'(s2_reg.lxx) + 51'(s2_reg.lyy) + 51'(s2_reg.lzz)
                  - 51'(s2_reg.rr);

        // split products keep every multiplier at 25x25 or below
        h_mag = s3_reg.h[49] ? 49'(-s3_reg.h) : 49'(s3_reg.h);
        c_mag = s3_reg.c[50] ? 50'(-s3_reg.c) : 50'(s3_reg.c);
        s4_next.a      = s3_reg.a;
        s4_next.h      = s3_reg.h;
        s4_next.miss   = (s3_reg.a == '0);
        s4_next.c_neg  = s3_reg.c[50];
        s4_next.p_h11  = 48'(h_mag[48:25]) * 48'(h_mag[48:25]);
        s4_next.p_h10  = 49'(h_mag[48:25]) * 49'(h_mag[24:0]);
        s4_next.p_h00  = 50'(h_mag[24:0]) * 50'(h_mag[24:0]);
        s4_next.p_a1c1 = 49'(s3_reg.a[47:24]) * 49'(c_mag[49:25]);
        s4_next.p_a1c0 = 49'(s3_reg.a[47:24]) * 49'(c_mag[24:0]);
        s4_next.p_a0c1 = 49'(s3_reg.a[23:0]) * 49'(c_mag[49:25]);
        s4_next.p_a0c0 = 49'(s3_reg.a[23:0]) * 49'(c_mag[24:0]);

        s5_next.a     = s4_reg.a;
        s5_next.h     = s4_reg.h;
        s5_next.miss  = s4_reg.miss;
        s5_next.c_neg = s4_reg.c_neg;
        s5_next.hh = (DISC_W'(s4_reg.p_h11) << 50) + (DISC_W'(s4_reg.p_h10) << 26)
                   + DISC_W'(s4_reg.p_h00);
        s5_next.ac = (DISC_W'(s4_reg.p_a1c1) << 49) + (DISC_W'(s4_reg.p_a1c0) << 24)
                   + (DISC_W'(s4_reg.p_a0c1) << 25) + DISC_W'(s4_reg.p_a0c0);

        s6_next.disc = s5_reg.c_neg ? s5_reg.hh + s5_reg.ac : s5_reg.hh - s5_reg.ac;
        s6_next.rem  = '0;
        s6_next.root = '0;
        s6_next.h    = s5_reg.h;
        s6_next.a    = s5_reg.a;
        s6_next.miss = s5_reg.miss || (!s5_reg.c_neg && (s5_reg.ac > s5_reg.hh));
    end

    // square root, one result bit per stage
    always_comb
    begin
        logic [SREM_W-1:0] rem_sh, trial;
        logic ge;
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            sq_prev[k] = (k == 0) ? s6_reg : sq_reg[(k == 0) ? 0 : k - 1];
            rem_sh = {sq_prev[k].rem[SREM_W-3:0], sq_prev[k].disc[DISC_W-1 -: 2]};
            trial  = SREM_W'({sq_prev[k].root, 2'b01});
            ge     = (rem_sh >= trial);
            sq_next[k]      = sq_prev[k];
            sq_next[k].rem  = ge ? rem_sh - trial : rem_sh;
            sq_next[k].root = {sq_prev[k].root[ROOT_W-2:0], ge};
            sq_next[k].disc = sq_prev[k].disc << 2;
        end
    end

    // numerator and range check
    always_comb
    begin
        logic signed [51:0] num;
        num = 52'(sq_reg[SQ_STAGES-1].h) - 52'(sq_reg[SQ_STAGES-1].root);
        n1_next.neg  = num[51];
        n1_next.nm   = num[51] ? 51'(-num) : 51'(num);
        n1_next.a    = sq_reg[SQ_STAGES-1].a;
        n1_next.miss = sq_reg[SQ_STAGES-1].miss;

        n2_next.rem    = DREM_W'(n1_reg.nm) << T_FRAC_BITS;
        n2_next.q      = '0;
        n2_next.a      = n1_reg.a;
        n2_next.neg    = n1_reg.neg;
        n2_next.miss   = n1_reg.miss;
        n2_next.presat = (64'(n1_reg.nm) >=
                          (64'(n1_reg.a) << (31 - T_FRAC_BITS)) + 64'(n1_reg.a));
    end

    // restoring divider, one quotient bit per stage
    always_comb
    begin
        logic [DREM_W-1:0] dsh;
        logic ge;
        for (int k = 0; k < DV_STAGES; k++)
        begin
            dv_prev[k] = (k == 0) ? n2_reg : dv_reg[(k == 0) ? 0 : k - 1];
            dsh = DREM_W'(dv_prev[k].a) << (DV_STAGES - 1 - k);
            ge  = (dv_prev[k].rem >= dsh);
            dv_next[k]     = dv_prev[k];
            dv_next[k].rem = ge ? dv_prev[k].rem - dsh : dv_prev[k].rem;
            dv_next[k].q   = {dv_prev[k].q[Q_W-2:0], ge};
        end
    end

    // rounding and saturation
    always_comb
    begin
        logic [Q_W:0] qq;
        qq = {1'b0, dv_reg[DV_STAGES-1].q}
           + (Q_W+1)'(dv_reg[DV_STAGES-1].neg && (dv_reg[DV_STAGES-1].rem != '0));
        hit_next = 1'b1;
        sat_next = 1'b0;
        t_next   = dv_reg[DV_STAGES-1].q;
        if (dv_reg[DV_STAGES-1].miss)
        begin
            hit_next = 1'b0;
            t_next   = T_MISS;
        end
        else if (dv_reg[DV_STAGES-1].presat)
        begin
            sat_next = 1'b1;
            t_next   = dv_reg[DV_STAGES-1].neg ? T_MIN : T_MAX;
        end
        else if (!dv_reg[DV_STAGES-1].neg)
        begin
            if (dv_reg[DV_STAGES-1].q > T_MAX)
            begin
                sat_next = 1'b1;
                t_next   = T_MAX;
            end
        end
        else if (qq > {1'b0, T_MIN})
        begin
            sat_next = 1'b1;
            t_next   = T_MIN;
        end
        else
        begin
            t_next = 32'((Q_W+1)'(0) - qq);
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            sq_vld_reg  <= '0;
            n1_vld_reg  <= 1'b0;
            n2_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= s_axis_tvalid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            sq_vld_reg  <= {sq_vld_reg[SQ_STAGES-2:0], s6_vld_reg};
            n1_vld_reg  <= sq_vld_reg[SQ_STAGES-1];
            n2_vld_reg  <= n1_vld_reg;
            dv_vld_reg  <= {dv_vld_reg[DV_STAGES-2:0], n2_vld_reg};
            out_vld_reg <= dv_vld_reg[DV_STAGES-1];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            n1_reg <= n1_next;
            n2_reg <= n2_next;
            for (int k = 0; k < DV_STAGES; k++)
            begin
                dv_reg[k] <= dv_next[k];
            end
            t_reg   <= t_next;
            hit_reg <= hit_next;
            sat_reg <= sat_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = t_reg;
    assign m_axis_tuser  = {sat_reg, hit_reg};

    a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == T_MISS && !m_axis_tuser[1])
        else $error("miss result without miss code");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(sq_vld_reg) && $stable(dv_vld_reg))
        else $error("pipeline moved during stall");

    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld_reg[SQ_STAGES-1] |->
            sq_reg[SQ_STAGES-1].rem <= SREM_W'({sq_reg[SQ_STAGES-1].root, 1'b0}))
        else $error("square root remainder out of range");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[DV_STAGES-1] && !dv_reg[DV_STAGES-1].miss && !dv_reg[DV_STAGES-1].presat
            |-> dv_reg[DV_STAGES-1].rem < DREM_W'(dv_reg[DV_STAGES-1].a))
        else $error("divider remainder not below divisor");

endmodule
